/* src/sfr_pkg.sv */
// shared types and constants for the stream find-and-replace block
`default_nettype none

package sfr_pkg;

    // widest pattern or replacement text, in bytes, and the config data width
    localparam int MAX_BYTES   = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int LEN_W       = 4;

    // defaults for the top-level parameters
    localparam int PAT_MAX_DEF = 8;
    localparam int REP_MAX_DEF = 8;
    localparam int Q_DEPTH_DEF = 4;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MATCH_TEXT   = 2'd0,
        REG_MATCH_LEN    = 2'd1,
        REG_REPLACE_TEXT = 2'd2,
        REG_REPLACE_LEN  = 2'd3
    } cfg_reg_t;

    // one burst of output bytes, produced by the front for one request
    typedef struct packed {
        logic [MAX_BYTES*8-1:0] data;   // first byte in the lowest eight bits
        logic [LEN_W-1:0]       n;      // bytes to send, zero only for an end marker
        logic                   last;   // burst closes the stream
    } cmd_t;

endpackage

`default_nettype wire

/* src/sfr_front.sv */
// front end: config registers, match window and burst command generation
`default_nettype none

module sfr_front #(
    parameter int PAT_MAX = sfr_pkg::PAT_MAX_DEF,
    parameter int REP_MAX = sfr_pkg::REP_MAX_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            accept,
    input  wire logic [7:0]                      in_byte,
    input  wire logic                            in_last,
    output logic                                 cmd_push,
    output sfr_pkg::cmd_t                        cmd
);

    localparam int CW = $clog2(PAT_MAX + 1);
    localparam int PW = PAT_MAX * 8;
    localparam int RW = REP_MAX * 8;
    localparam int LW = sfr_pkg::LEN_W;
    localparam int DW = sfr_pkg::MAX_BYTES * 8;

    logic [PW-1:0] match_text_reg;
    logic [LW-1:0] match_len_reg;
    logic [RW-1:0] replace_text_reg;
    logic [LW-1:0] replace_len_reg;
    logic [7:0]    win_reg [PAT_MAX];
    logic [7:0]    win_next [PAT_MAX];
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    logic [LW-1:0] mlen;
    logic [LW-1:0] rlen;
    logic [LW-1:0] cnt_ext;
    logic [LW-1:0] base;
    logic [LW-1:0] cnt_new;
    logic          win_full;
    logic          hit;
    logic [7:0]    win_ins [PAT_MAX];
    logic [7:0]    win_shift [PAT_MAX];
    logic [PAT_MAX-1:0] byte_eq;
    logic [DW-1:0] win_flat;

    // lengths clamped to the hardware maximum
    assign mlen = (match_len_reg > LW'(PAT_MAX)) ? LW'(PAT_MAX) : match_len_reg;
    assign rlen = (replace_len_reg > LW'(REP_MAX)) ? LW'(REP_MAX) : replace_len_reg;

    // slot for the new byte
    assign cnt_ext  = LW'(cnt_reg);
    assign base     = (cnt_ext >= mlen) ? '0 : cnt_ext;
    assign cnt_new  = base + LW'(1);
    assign win_full = (cnt_new == mlen);
    assign hit      = &byte_eq;

    // window with the new byte written in, compared bytewise to the pattern
    always_comb
    begin
        win_flat = '0;
        for (int i = 0; i < PAT_MAX; i++)
        begin
            win_ins[i]       = (LW'(i) == base) ? in_byte : win_reg[i];
            byte_eq[i]       = (LW'(i) >= mlen) || (win_ins[i] == match_text_reg[i*8 +: 8]);
            win_flat[i*8 +: 8] = win_ins[i];
            win_shift[i]     = 8'h00;
        end
        for (int i = 0; i < PAT_MAX - 1; i++)
        begin
            win_shift[i] = win_ins[i+1];
        end
    end

    // build the burst for this request and the next window state
    always_comb
    begin
        cmd.last = in_last;
        cmd.data = win_flat;
        cmd.n    = '0;
        cnt_next = CW'(cnt_new);
        win_next = win_ins;
        if (mlen == '0)
        begin
            cmd.data = DW'(in_byte);
            cmd.n    = LW'(1);
            cnt_next = '0;
        end
        else if (win_full && hit)
        begin
            cmd.data = DW'(replace_text_reg);
            cmd.n    = rlen;
            cnt_next = '0;
        end
        else if (win_full)
        begin
            cmd.n    = in_last ? mlen : LW'(1);
            cnt_next = in_last ? '0 : CW'(mlen - LW'(1));
            win_next = win_shift;
        end
        else
        begin
            cmd.n    = in_last ? cnt_new : '0;
            cnt_next = in_last ? '0 : CW'(cnt_new);
        end
    end

    assign cmd_push = accept && ((cmd.n != '0) || in_last);

    // config registers and window count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_text_reg   <= '0;
            match_len_reg    <= '0;
            replace_text_reg <= '0;
            replace_len_reg  <= '0;
            cnt_reg          <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (sfr_pkg::cfg_reg_t'(cfg_index))
                sfr_pkg::REG_MATCH_TEXT:
                begin
                    match_text_reg <= cfg_data[PW-1:0];
                end
                sfr_pkg::REG_MATCH_LEN:
                begin
                    match_len_reg <= cfg_data[LW-1:0];
                    cnt_reg       <= '0;
                end
                sfr_pkg::REG_REPLACE_TEXT:
                begin
                    replace_text_reg <= cfg_data[RW-1:0];
                end
                sfr_pkg::REG_REPLACE_LEN:
                begin
                    replace_len_reg <= cfg_data[LW-1:0];
                end
            endcase
        end
        else if (accept)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // window bytes, only meaningful below the count
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_next;
        end
    end

`ifndef SYNTHESIS
    // held bytes never reach the pattern length
    a_cnt_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) || (LW'(cnt_reg) < mlen))
        else $error("window count not below match length");
`endif

endmodule

`default_nettype wire

/* src/sfr_cmd_queue.sv */
// short command queue between the front and back ends
`default_nettype none

module sfr_cmd_queue #(
    parameter int DEPTH = sfr_pkg::Q_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire sfr_pkg::cmd_t wr_cmd,
    output logic               q_full,
    input  wire logic          rd_en,
    output sfr_pkg::cmd_t      head,
    output logic               q_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    sfr_pkg::cmd_t slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [NW-1:0] q_cnt_reg;
    logic [NW-1:0] q_cnt_next;

    assign q_full  = (q_cnt_reg == NW'(DEPTH));
    assign q_empty = (q_cnt_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        if (wr_en && !rd_en)
        begin
            q_cnt_next = q_cnt_reg + NW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            q_cnt_next = q_cnt_reg - NW'(1);
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

    // command storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

`ifndef SYNTHESIS
    // never written while full, never read while empty
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("command queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !q_empty)
        else $error("command queue read while empty");
`endif

endmodule

`default_nettype wire

/* src/sfr_back.sv */
// back end: expands queued bursts into single output bytes
`default_nettype none

module sfr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sfr_pkg::cmd_t head,
    input  wire logic          q_empty,
    output logic               q_rd,
    input  wire logic          pop,
    output logic               empty,
    output logic [7:0]         out_byte,
    output logic               byte_valid,
    output logic               out_last
);

    localparam int LW = sfr_pkg::LEN_W;
    localparam int IW = $clog2(sfr_pkg::MAX_BYTES);

    logic [IW-1:0] idx_reg;
    logic          has_reg;
    logic [7:0]    out_byte_reg;
    logic          byte_valid_reg;
    logic          out_last_reg;

    logic          load;
    logic          cmd_end;
    logic          marker;

    assign marker  = (head.n == '0);
    assign cmd_end = marker || (LW'(idx_reg) == head.n - LW'(1));
    assign load    = !q_empty && (!has_reg || pop);
    assign q_rd    = load && cmd_end;

    // byte position inside the current burst
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            has_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg <= cmd_end ? '0 : idx_reg + IW'(1);
                has_reg <= 1'b1;
            end
            else if (pop)
            begin
                has_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= marker ? 8'h00 : head.data[idx_reg*8 +: 8];
            byte_valid_reg <= !marker;
            out_last_reg   <= cmd_end && head.last;
        end
    end

    assign empty      = !has_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign out_last   = out_last_reg;

`ifndef SYNTHESIS
    // a burst in progress keeps its command at the queue head
    a_burst_head_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> !q_empty)
        else $error("burst in progress without a queued command");
`endif

endmodule

`default_nettype wire

/* src/stream_find_replace_core.sv */
// top level of the stream find-and-replace block
//
//  channel   direction  handshake                 payload
//  input     in         push / full               in_byte, in_last
//  result    out        empty / pop               out_byte, byte_valid, out_last
//  config    in         cfg_wr_en (no wait)       cfg_index, cfg_data
//
// The front takes one request per cycle while the command queue has room.
// The back sends one result byte per cycle while results are popped, so a
// request that yields n bytes holds it until all are sent; the queue absorbs
// bursts from replacements and flushes, in slots ahead of the output register.
// Reset clears the config registers, window count, queue and output stage.
`default_nettype none

module stream_find_replace_core #(
    parameter int PAT_MAX = sfr_pkg::PAT_MAX_DEF,
    parameter int REP_MAX = sfr_pkg::REP_MAX_DEF,
    parameter int Q_DEPTH = sfr_pkg::Q_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [7:0]                      in_byte,
    input  wire logic                            in_last,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [7:0]                           out_byte,
    output logic                                 byte_valid,
    output logic                                 out_last
);

    logic          accept;
    logic          cmd_push;
    sfr_pkg::cmd_t cmd;
    sfr_pkg::cmd_t head;
    logic          q_full;
    logic          q_empty;
    logic          q_rd;

    assign full   = q_full;
    assign accept = push && !q_full;

    // window, matching and burst generation
    sfr_front #(
        .PAT_MAX (PAT_MAX),
        .REP_MAX (REP_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    // decoupling queue
    sfr_cmd_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_cmd  (cmd),
        .q_full  (q_full),
        .rd_en   (q_rd),
        .head    (head),
        .q_empty (q_empty)
    );

    // byte serializer and output stage
    sfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .q_rd       (q_rd),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .out_last   (out_last)
    );

endmodule

`default_nettype wire
